FILE: hdl/crc16_frame_checker_unit_macros.svh
// Assertion macros for the CRC-16 frame checker.
`ifndef CRC16_FRAME_CHECKER_UNIT_MACROS_SVH
`define CRC16_FRAME_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CRCFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crcfc: implication check failed");
`define CRCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crcfc: next-cycle check failed");
`else
`define CRCFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CRCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/crcfc_pkg.sv
package crcfc_pkg;

    localparam int unsigned POS_W     = 4;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [POS_W-1:0] FRAME_LEN  = 4'd11;
    localparam logic [POS_W-1:0] HDR_LEN    = 4'd8;
    localparam logic [POS_W-1:0] POS_CMD    = 4'd8;
    localparam logic [POS_W-1:0] POS_CRC_LO = 4'd9;
    localparam logic [POS_W-1:0] POS_CRC_HI = 4'd10;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [63:0] HEADER_RESET  = 64'hA3A4_0000_0003_101B;
    localparam logic [7:0]  MAX_CMD_RESET = 8'h57;
    localparam logic [7:0]  ACK_RESET     = 8'h55;
    localparam logic [7:0]  NAK_RESET     = 8'h56;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CMD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAK     = 8'd3;

    typedef enum logic [2:0] {
        VERDICT_ACK    = 3'd0,
        VERDICT_NAK    = 3'd1,
        VERDICT_OTHER  = 3'd2,
        VERDICT_HEADER = 3'd3,
        VERDICT_CRC    = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [63:0] header_word;
        logic [7:0]  max_command;
        logic [7:0]  ack_code;
        logic [7:0]  nak_code;
    } cfg_t;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hdl/crcfc_cfg_regs.sv
module crcfc_cfg_regs
    import crcfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_word <= HEADER_RESET;
            cfg_reg.max_command <= MAX_CMD_RESET;
            cfg_reg.ack_code    <= ACK_RESET;
            cfg_reg.nak_code    <= NAK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER:  cfg_reg.header_word <= cfg_data;
                CFG_MAX_CMD: cfg_reg.max_command <= cfg_data[7:0];
                CFG_ACK:     cfg_reg.ack_code    <= cfg_data[7:0];
                CFG_NAK:     cfg_reg.nak_code    <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

endmodule

FILE: hdl/crcfc_core.sv
`include "crc16_frame_checker_unit_macros.svh"

module crcfc_core
    import crcfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    output logic       res_valid,
    input  logic       res_ready,
    output verdict_t   res_verdict,
    output logic [7:0] res_command
);

    // input stage
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;

    // result stage
    logic       out_vld_reg;
    verdict_t   out_verdict_reg, out_verdict_next;
    logic [7:0] out_cmd_reg;

    logic [POS_W-1:0] pos_eff;
    logic [15:0]      crc_eff;
    logic             hdr_ok_eff;
    logic [7:0]       cmd_eff;
    logic [7:0]       crc_lo_eff;
    logic             active;
    logic             emits;
    logic             out_free;
    logic             process;
    logic [2:0]       hdr_sel;
    logic [7:0]       hdr_want;
    logic [15:0]      crc_upd;
    logic             crc_ok;

    // a start byte resets the frame state before it is itself consumed
    assign pos_eff    = in_start_reg ? '0 : pos_reg;
    assign crc_eff    = in_start_reg ? '0 : crc_reg;
    assign hdr_ok_eff = in_start_reg ? 1'b1 : hdr_ok_reg;
    assign cmd_eff    = in_start_reg ? '0 : cmd_reg;
    assign crc_lo_eff = in_start_reg ? '0 : crc_lo_reg;

    assign active   = pos_eff < FRAME_LEN;
    assign emits    = in_vld_reg && active && (pos_eff == POS_CRC_HI);
    assign out_free = !out_vld_reg || res_ready;
    assign process  = in_vld_reg && (out_free || !emits);
    assign in_ready = !in_vld_reg || process;

    assign hdr_sel  = 3'd7 - pos_eff[2:0];
    assign hdr_want = cfg.header_word[{hdr_sel, 3'b000} +: 8];
    assign crc_upd  = crc16_byte(crc_eff, in_byte_reg);
    assign crc_ok   = (crc_lo_eff == crc_eff[7:0]) && (in_byte_reg == crc_eff[15:8]);

    always_comb
    begin
        pos_next    = pos_eff;
        crc_next    = crc_eff;
        hdr_ok_next = hdr_ok_eff;
        cmd_next    = cmd_eff;
        crc_lo_next = crc_lo_eff;
        if (active)
        begin
            pos_next = pos_eff + 4'd1;
            if (pos_eff < HDR_LEN)
            begin
                if (in_byte_reg != hdr_want)
                    hdr_ok_next = 1'b0;
                crc_next = crc_upd;
            end
            else if (pos_eff == POS_CMD)
            begin
                cmd_next = in_byte_reg;
                crc_next = crc_upd;
            end
            else if (pos_eff == POS_CRC_LO)
            begin
                crc_lo_next = in_byte_reg;
            end
            else
            begin
                pos_next = FRAME_LEN;
            end
        end
    end

    always_comb
    begin
        if (!hdr_ok_eff)
            out_verdict_next = VERDICT_HEADER;
        else if (cmd_eff > cfg.max_command)
            out_verdict_next = VERDICT_OTHER;
        else if (!crc_ok)
            out_verdict_next = VERDICT_CRC;
        else if (cmd_eff == cfg.ack_code)
            out_verdict_next = VERDICT_ACK;
        else if (cmd_eff == cfg.nak_code)
            out_verdict_next = VERDICT_NAK;
        else
            out_verdict_next = VERDICT_OTHER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pos_reg     <= FRAME_LEN;
            crc_reg     <= '0;
            hdr_ok_reg  <= 1'b1;
            cmd_reg     <= '0;
            crc_lo_reg  <= '0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (process)
            begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                hdr_ok_reg <= hdr_ok_next;
                cmd_reg    <= cmd_next;
                crc_lo_reg <= crc_lo_next;
            end
            if (process && emits)
                out_vld_reg <= 1'b1;
            else if (res_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg  <= in_byte;
            in_start_reg <= in_start;
        end
        if (process && emits)
        begin
            out_verdict_reg <= out_verdict_next;
            out_cmd_reg     <= cmd_eff;
        end
    end

    assign res_valid   = out_vld_reg;
    assign res_verdict = out_verdict_reg;
    assign res_command = out_cmd_reg;

    `CRCFC_ASSERT_IMPLY(a_pos_range, clk, rst_n, 1'b1, pos_reg <= FRAME_LEN)
    `CRCFC_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, process && emits, out_free)
    `CRCFC_ASSERT_NEXT(a_emit_valid, clk, rst_n, process && emits, out_vld_reg)
    `CRCFC_ASSERT_NEXT(a_emit_idle, clk, rst_n, process && emits, pos_reg == FRAME_LEN)
    `CRCFC_ASSERT_IMPLY(a_verdict_code, clk, rst_n, out_vld_reg, out_verdict_reg <= VERDICT_CRC)

endmodule

FILE: hdl/crc16_frame_checker_unit.sv
// An accepted byte is held in the input register and processed from there; on the last
// frame byte the verdict word is registered in the result stage before it is offered.
// Throughput: one byte per cycle; a stalled result only holds bytes that would emit.
// Reset (rst_n, async low): idle until a frame start, configuration registers to defaults.
module crc16_frame_checker_unit
    import crcfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]           s_axis_tuser,   // [0] frame_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [2:0] verdict, [10:3] command_byte, rest 0
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    cfg_t       cfg;
    verdict_t   verdict;
    logic [7:0] command_byte;

    crcfc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crcfc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_start    (s_axis_tuser[0]),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_verdict (verdict),
        .res_command (command_byte)
    );

    assign m_axis_tdata = {5'b00000, command_byte, verdict};

endmodule

FILE: dv/crcfc_verdict_checker.sv
`timescale 1ns / 100ps

package crcfc_frame_pkg;
    import crcfc_pkg::*;

    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] command;
    } verdict_word_t;

    // XMODEM CRC, one bit of data at a time, MSB first
    function automatic logic [15:0] crc_xmodem_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ data[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction
endpackage

module crcfc_verdict_checker
    import crcfc_pkg::*;
    import crcfc_frame_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]           s_axis_tuser,   // [0] frame_start
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [15:0]          m_axis_tdata,   // [2:0] verdict, [10:3] command_byte
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output int unsigned          mismatch_count,
    output int unsigned          results_pending
);

    cfg_t          shadow_cfg;
    logic [3:0]    frame_pos;
    logic [15:0]   crc_run;
    logic          header_ok;
    logic [7:0]    cmd_seen;
    logic [7:0]    crc_low_seen;
    verdict_word_t awaited_verdicts[$];
    int unsigned   misses;

    // Walks one received byte through the frame layout; returns 1 when a verdict falls out.
    function automatic logic absorb_byte(input logic [7:0] rx, input logic start,
                                         output verdict_word_t res);
        int unsigned p;
        logic        crc_ok;
        res = '0;
        if (start)
        begin
            frame_pos    = '0;
            crc_run      = '0;
            header_ok    = 1'b1;
            cmd_seen     = '0;
            crc_low_seen = '0;
        end
        p = frame_pos;
        if (frame_pos >= FRAME_LEN)
            return 1'b0;
        if (frame_pos < HDR_LEN)
        begin
            if (rx != shadow_cfg.header_word[63 - 8*p -: 8])
                header_ok = 1'b0;
            crc_run = crc_xmodem_next(crc_run, rx);
        end
        else if (frame_pos == POS_CMD)
        begin
            cmd_seen = rx;
            crc_run  = crc_xmodem_next(crc_run, rx);
        end
        else if (frame_pos == POS_CRC_LO)
        begin
            crc_low_seen = rx;
        end
        else
        begin
            crc_ok = (crc_low_seen == crc_run[7:0]) && (rx == crc_run[15:8]);
            if (!header_ok)
                res.verdict = VERDICT_HEADER;
            else if (cmd_seen > shadow_cfg.max_command)
                res.verdict = VERDICT_OTHER;
            else if (!crc_ok)
                res.verdict = VERDICT_CRC;
            else if (cmd_seen == shadow_cfg.ack_code)
                res.verdict = VERDICT_ACK;
            else if (cmd_seen == shadow_cfg.nak_code)
                res.verdict = VERDICT_NAK;
            else
                res.verdict = VERDICT_OTHER;
            res.command = cmd_seen;
            frame_pos   = FRAME_LEN;
            return 1'b1;
        end
        frame_pos = frame_pos + 4'd1;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : observe
        verdict_word_t want;
        verdict_word_t fresh;
        if (!rst_n)
        begin
            shadow_cfg      = {HEADER_RESET, MAX_CMD_RESET, ACK_RESET, NAK_RESET};
            frame_pos       = FRAME_LEN;
            crc_run         = '0;
            header_ok       = 1'b1;
            cmd_seen        = '0;
            crc_low_seen    = '0;
            misses          = 0;
            awaited_verdicts.delete();
            mismatch_count  <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_HEADER:  shadow_cfg.header_word = cfg_data;
                    CFG_MAX_CMD: shadow_cfg.max_command = cfg_data[7:0];
                    CFG_ACK:     shadow_cfg.ack_code    = cfg_data[7:0];
                    CFG_NAK:     shadow_cfg.nak_code    = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    if (misses < 10)
                        $display("%0t: unexpected verdict word %0d cmd %02h", $realtime,
                                 m_axis_tdata[2:0], m_axis_tdata[10:3]);
                    misses++;
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    if (m_axis_tdata[2:0] != want.verdict || m_axis_tdata[10:3] != want.command)
                    begin
                        if (misses < 10)
                            $display("%0t: expected verdict %0d cmd %02h, got verdict %0d cmd %02h",
                                     $realtime, want.verdict, want.command,
                                     m_axis_tdata[2:0], m_axis_tdata[10:3]);
                        misses++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (absorb_byte(s_axis_tdata, s_axis_tuser[0], fresh))
                    awaited_verdicts.push_back(fresh);
            end
            mismatch_count  <= misses;
            results_pending <= awaited_verdicts.size();
        end
    end

endmodule

FILE: dv/crc16_frame_checker_unit_tb.sv
`timescale 1ns / 100ps

module crc16_frame_checker_unit_tb;
    import crcfc_pkg::*;
    import crcfc_frame_pkg::*;

    localparam int PHASES          = 8;
    localparam int BYTES_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = 6;
    localparam int QUIET_LIMIT     = 2000;

    typedef logic [7:0] frame_t [FRAME_LEN];

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] rx_byte
    logic [0:0]           s_axis_tuser;   // [0] frame_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // [2:0] verdict, [10:3] command_byte, rest 0
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    int unsigned mismatch_count;
    int unsigned results_pending;
    cfg_t        settings_now;
    logic        src_steady;
    logic        sink_steady;
    int          bytes_sent;

    crc16_frame_checker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    crcfc_verdict_checker verdict_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic frame_t build_frame(input cfg_t s, input logic [7:0] cmd);
        frame_t      f;
        logic [15:0] crc;
        crc = '0;
        for (int p = 0; p < HDR_LEN; p++)
            f[p] = s.header_word[63 - 8*p -: 8];
        f[POS_CMD] = cmd;
        for (int p = 0; p <= POS_CMD; p++)
            crc = crc_xmodem_next(crc, f[p]);
        f[POS_CRC_LO] = crc[7:0];
        f[POS_CRC_HI] = crc[15:8];
        return f;
    endfunction

    function automatic cfg_t pick_settings(input int phase);
        cfg_t s;
        s.header_word = {$urandom, $urandom};
        s.max_command = 8'($urandom_range(0, 255));
        s.ack_code    = 8'($urandom_range(0, s.max_command));
        s.nak_code    = 8'($urandom_range(0, s.max_command));
        case (phase)
            1: s = {64'h0, 8'hFF, 8'h00, 8'hFF};
            2: s = {64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h00, 8'h00};
            3: s.nak_code = s.ack_code;
            4: s = {s.header_word, 8'hFF, 8'hFF, 8'h00};
            5:
            begin
                s.ack_code = 8'($urandom_range(0, 255));
                s.nak_code = 8'($urandom_range(0, 255));
            end
            7: s = {HEADER_RESET, MAX_CMD_RESET, ACK_RESET, NAK_RESET};
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= b;
        s_axis_tuser[0] <= start;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_run(input frame_t f, input int count);
        for (int p = 0; p < count; p++)
            send_byte(f[p], p == 0);
    endtask

    // hold off until every verdict is out and the pipe has flushed
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input cfg_t s);
        put_register(CFG_HEADER, s.header_word);
        put_register(CFG_MAX_CMD, {56'd0, s.max_command});
        put_register(CFG_ACK, {56'd0, s.ack_code});
        put_register(CFG_NAK, {56'd0, s.nak_code});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_frame();
        frame_t     f;
        logic [7:0] cmd;
        int         kind;
        int         cut;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0)
            src_steady = !src_steady;
        if (kind < 8)
        begin
            // line noise; now and then a stray frame start
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            return;
        end
        case ($urandom_range(0, 3))
            0:       cmd = settings_now.ack_code;
            1:       cmd = settings_now.nak_code;
            2:       cmd = 8'($urandom_range(0, settings_now.max_command));
            default: cmd = 8'($urandom_range(0, 255));
        endcase
        f = build_frame(settings_now, cmd);
        cut = FRAME_LEN;
        if (kind < 20)
            f[$urandom_range(0, HDR_LEN - 1)] ^= 8'h01 << $urandom_range(0, 7);
        else if (kind < 32)
            f[POS_CRC_LO + $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
        else if (kind < 42)
            cut = $urandom_range(1, FRAME_LEN - 1);
        send_run(f, cut);
        if (kind >= 42 && kind < 50)
        begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        if ($urandom_range(0, 49) == 0)
            settle();
    endtask

    initial
    begin : sink
        int hold;
        m_axis_tready <= 1'b0;
        sink_steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
                sink_steady = !sink_steady;
            hold = sink_steady ? 0 : $urandom_range(0, 19);
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        frame_t f;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        src_steady    = 1'b0;
        bytes_sent    = 0;
        settings_now  = {HEADER_RESET, MAX_CMD_RESET, ACK_RESET, NAK_RESET};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle byte, partial frame cut by a new start, good ack, trailing byte,
        // then an over-max command with a broken CRC (over-max wins)
        send_byte(8'h00, 1'b0);
        f = build_frame(settings_now, ACK_RESET);
        send_run(f, 3);
        send_run(f, FRAME_LEN);
        send_byte(8'hFF, 1'b0);
        f = build_frame(settings_now, 8'hFF);
        f[POS_CRC_HI] ^= 8'h80;
        send_run(f, FRAME_LEN);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                settle();
                settings_now = pick_settings(phase);
                load_settings(settings_now);
            end
            bytes_sent = 0;
            while (bytes_sent < BYTES_PER_PHASE)
                send_random_frame();
        end

        settle();
        if (mismatch_count == 0 && results_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
